// ===== src/qsvl_pkg.sv =====
`default_nettype none

package qsvl_pkg;

   // default sizing
   localparam int MAX_PAIRS_DEF          = 15;
   localparam int QUERY_BUFFER_BYTES_DEF = 1024;
   localparam int NAME_BYTES_DEF         = 32;
   localparam int VALUE_BYTES_DEF        = 32;

   // characters
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_EQUALS = 8'h3D;
   localparam logic [7:0] CHAR_AMP    = 8'h26;

   // item kind
   localparam logic MODE_NAME  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // end-of-parse status codes
   localparam logic [1:0] STATUS_CLEAN  = 2'd0;
   localparam logic [1:0] STATUS_SYNTAX = 2'd1;
   localparam logic [1:0] STATUS_PAIRS  = 2'd2;
   localparam logic [1:0] STATUS_LENGTH = 2'd3;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] value_byte;
      logic       byte_valid;
      logic       run_last;
      logic       found;
      logic       truncated;
      logic [1:0] status;
      logic [3:0] pair_total;
   } rsp_type;

   // parse result handed from parser to the output sequencer
   typedef struct packed {
      logic       found;
      logic       truncated;
      logic [1:0] status;
      logic [3:0] pair_total;
   } summary_type;

endpackage

`default_nettype wire

// ===== src/qsvl_value_buf.sv =====
`default_nettype none

module qsvl_value_buf #(
   parameter int VALUE_BYTES = qsvl_pkg::VALUE_BYTES_DEF,
   localparam int VAW = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1
) (
   input  wire logic           clock,
   input  wire logic           wr_en,
   input  wire logic [VAW-1:0] wr_addr,
   input  wire logic [7:0]     wr_data,
   input  wire logic [VAW-1:0] rd_addr,
   output logic [7:0]          rd_data
);

   logic [7:0] mem [VALUE_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/qsvl_parser.sv =====
`default_nettype none

module qsvl_parser #(
   parameter int MAX_PAIRS          = qsvl_pkg::MAX_PAIRS_DEF,
   parameter int QUERY_BUFFER_BYTES = qsvl_pkg::QUERY_BUFFER_BYTES_DEF,
   parameter int NAME_BYTES         = qsvl_pkg::NAME_BYTES_DEF,
   parameter int VALUE_BYTES        = qsvl_pkg::VALUE_BYTES_DEF,
   localparam int NAW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1,
   localparam int NLW = $clog2(NAME_BYTES + 1),
   localparam int VAW = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1,
   localparam int VLW = $clog2(VALUE_BYTES + 1),
   localparam int QW  = (QUERY_BUFFER_BYTES > 2) ? $clog2(QUERY_BUFFER_BYTES) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 exec,
   input  wire logic                 clear,
   input  wire qsvl_pkg::req_type    item,
   output qsvl_pkg::summary_type     summary,
   output logic [VLW-1:0]            value_len,
   output logic                      val_we,
   output logic [VAW-1:0]            val_waddr,
   output logic [7:0]                val_wdata
);

   // name store, read at the current key position every cycle
   logic [7:0]     name_mem [NAME_BYTES];
   logic [7:0]     name_q_ff;
   logic           name_we;
   logic [NAW-1:0] name_waddr;

   logic [NLW-1:0] name_len_ff, name_len_in;
   logic           too_long_ff, too_long_in;
   logic           closed_ff, closed_in;
   logic           phase_ff, phase_in;
   logic           reading_ff, reading_in;
   logic           ended_ff, ended_in;
   logic [QW-1:0]  qcount_ff, qcount_in;
   logic [3:0]     pairs_ff, pairs_in;
   logic [NLW-1:0] key_pos_ff, key_pos_in;
   logic           key_match_ff, key_match_in;
   logic [VLW-1:0] value_len_ff, value_len_in;
   logic           found_ff, found_in;
   logic           overflow_ff, overflow_in;
   logic [1:0]     status_ff, status_in;

   always_comb begin
      logic       do_fin;
      logic [1:0] fin_code;
      logic       km;

      do_fin       = 1'b0;
      fin_code     = qsvl_pkg::STATUS_CLEAN;
      km           = 1'b0;
      name_len_in  = name_len_ff;
      too_long_in  = too_long_ff;
      closed_in    = closed_ff;
      phase_in     = phase_ff;
      reading_in   = reading_ff;
      ended_in     = ended_ff;
      qcount_in    = qcount_ff;
      pairs_in     = pairs_ff;
      key_pos_in   = key_pos_ff;
      key_match_in = key_match_ff;
      value_len_in = value_len_ff;
      found_in     = found_ff;
      overflow_in  = overflow_ff;
      status_in    = status_ff;
      name_we      = 1'b0;
      name_waddr   = name_len_ff[NAW-1:0];
      val_we       = 1'b0;
      val_waddr    = value_len_ff[VAW-1:0];
      val_wdata    = item.data_byte;

      if (clear) begin
         reading_in   = 1'b0;
         ended_in     = 1'b0;
         qcount_in    = '0;
         pairs_in     = '0;
         key_pos_in   = '0;
         key_match_in = 1'b1;
         value_len_in = '0;
         found_in     = 1'b0;
         overflow_in  = 1'b0;
         status_in    = qsvl_pkg::STATUS_CLEAN;
      end else if (exec) begin
         if (item.mode == qsvl_pkg::MODE_NAME) begin
            // a name after query bytes starts over and drops the open parse
            if (phase_ff) begin
               phase_in     = 1'b0;
               name_len_in  = '0;
               too_long_in  = 1'b0;
               closed_in    = 1'b0;
               reading_in   = 1'b0;
               ended_in     = 1'b0;
               qcount_in    = '0;
               pairs_in     = '0;
               key_pos_in   = '0;
               key_match_in = 1'b1;
               value_len_in = '0;
               found_in     = 1'b0;
               overflow_in  = 1'b0;
               status_in    = qsvl_pkg::STATUS_CLEAN;
            end
            if (!closed_in) begin
               if (item.data_byte == qsvl_pkg::CHAR_NUL) begin
                  closed_in = 1'b1;
               end else if (name_len_in < NLW'(NAME_BYTES)) begin
                  name_we     = 1'b1;
                  name_waddr  = name_len_in[NAW-1:0];
                  name_len_in = name_len_in + 1'b1;
               end else begin
                  too_long_in = 1'b1;
               end
               if (item.last) begin
                  closed_in = 1'b1;
               end
            end
         end else begin
            phase_in  = 1'b1;
            closed_in = 1'b1;
            if (!ended_ff) begin
               if (item.data_byte == qsvl_pkg::CHAR_NUL) begin
                  do_fin   = 1'b1;
                  fin_code = qsvl_pkg::STATUS_CLEAN;
               end else if (qcount_ff >= QW'(QUERY_BUFFER_BYTES - 1)) begin
                  do_fin   = 1'b1;
                  fin_code = qsvl_pkg::STATUS_LENGTH;
               end else begin
                  qcount_in = qcount_ff + 1'b1;
                  if (item.data_byte == qsvl_pkg::CHAR_EQUALS) begin
                     if (reading_ff) begin
                        ended_in  = 1'b1;
                        status_in = qsvl_pkg::STATUS_SYNTAX;
                     end else begin
                        km = key_match_ff && !too_long_ff &&
                             (key_pos_ff == name_len_ff) && !found_ff;
                        key_match_in = km;
                        if (km) begin
                           value_len_in = '0;
                           overflow_in  = 1'b0;
                        end
                        reading_in = 1'b1;
                     end
                  end else if (item.data_byte == qsvl_pkg::CHAR_AMP) begin
                     if (!reading_ff) begin
                        ended_in  = 1'b1;
                        status_in = qsvl_pkg::STATUS_SYNTAX;
                     end else begin
                        pairs_in     = pairs_ff + 1'b1;
                        found_in     = found_ff | key_match_ff;
                        reading_in   = 1'b0;
                        key_pos_in   = '0;
                        key_match_in = 1'b1;
                        if (pairs_in >= 4'(MAX_PAIRS)) begin
                           ended_in  = 1'b1;
                           status_in = qsvl_pkg::STATUS_PAIRS;
                        end
                     end
                  end else if (reading_ff) begin
                     if (key_match_ff) begin
                        if (value_len_ff < VLW'(VALUE_BYTES)) begin
                           val_we       = 1'b1;
                           value_len_in = value_len_ff + 1'b1;
                        end else begin
                           overflow_in = 1'b1;
                        end
                     end
                  end else if (key_match_ff) begin
                     if (key_pos_ff < name_len_ff && name_q_ff == item.data_byte) begin
                        key_pos_in = key_pos_ff + 1'b1;
                     end else begin
                        key_match_in = 1'b0;
                     end
                  end
               end
               if (!do_fin && item.last && !ended_in) begin
                  do_fin   = 1'b1;
                  fin_code = qsvl_pkg::STATUS_CLEAN;
               end
               // a pending value counts as a pair on a clean or length end
               if (do_fin) begin
                  if (reading_in) begin
                     pairs_in     = pairs_in + 1'b1;
                     found_in     = found_in | key_match_in;
                     reading_in   = 1'b0;
                     key_pos_in   = '0;
                     key_match_in = 1'b1;
                  end
                  ended_in  = 1'b1;
                  status_in = fin_code;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (name_we) begin
         name_mem[name_waddr] <= item.data_byte;
      end
      name_q_ff <= name_mem[key_pos_ff[NAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_len_ff  <= '0;
         too_long_ff  <= 1'b0;
         closed_ff    <= 1'b0;
         phase_ff     <= 1'b0;
         reading_ff   <= 1'b0;
         ended_ff     <= 1'b0;
         qcount_ff    <= '0;
         pairs_ff     <= '0;
         key_pos_ff   <= '0;
         key_match_ff <= 1'b1;
         value_len_ff <= '0;
         found_ff     <= 1'b0;
         overflow_ff  <= 1'b0;
         status_ff    <= qsvl_pkg::STATUS_CLEAN;
      end else begin
         name_len_ff  <= name_len_in;
         too_long_ff  <= too_long_in;
         closed_ff    <= closed_in;
         phase_ff     <= phase_in;
         reading_ff   <= reading_in;
         ended_ff     <= ended_in;
         qcount_ff    <= qcount_in;
         pairs_ff     <= pairs_in;
         key_pos_ff   <= key_pos_in;
         key_match_ff <= key_match_in;
         value_len_ff <= value_len_in;
         found_ff     <= found_in;
         overflow_ff  <= overflow_in;
         status_ff    <= status_in;
      end
   end

   assign summary.found      = found_ff;
   assign summary.truncated  = found_ff & overflow_ff;
   assign summary.status     = status_ff;
   assign summary.pair_total = pairs_ff;
   assign value_len          = value_len_ff;

endmodule

`default_nettype wire

// ===== src/query_string_value_lookup_core.sv =====
`default_nettype none

// Query string value lookup.
// req_ channel: one beat per character. mode 0 beats load the wanted key
// name (ended by a 0 byte or last); mode 1 beats carry the query string
// key=value&key=value, parsed as they arrive.
// rsp_ channel: only the query's last beat produces output: one beat per
// byte of the matched value, or a single beat with byte_valid 0 when
// nothing matched or the value is empty. run_last marks the final beat;
// found, truncated, status and pair_total repeat on every beat of the run.
// Each request beat is captured in ST_IDLE, then compared in ST_EXEC against
// the name store, whose read is registered; the next beat is taken after that.
// After the query's last beat, each output beat passes ST_EMIT_RD and
// ST_EMIT_WR through the registered value store read port into rsp_data.
// req_stall stays high while an item or an output run is in progress.
// rsp_stall holds the output register; the run pauses, nothing is lost.
// Reset clears the name length, the parse state and the output valid; the
// name and value stores are not cleared (only written entries are read).

module query_string_value_lookup_core #(
   parameter int MAX_PAIRS          = qsvl_pkg::MAX_PAIRS_DEF,
   parameter int QUERY_BUFFER_BYTES = qsvl_pkg::QUERY_BUFFER_BYTES_DEF,
   parameter int NAME_BYTES         = qsvl_pkg::NAME_BYTES_DEF,
   parameter int VALUE_BYTES        = qsvl_pkg::VALUE_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire qsvl_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output qsvl_pkg::rsp_type      rsp_data
);

   localparam int VAW = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;
   localparam int VLW = $clog2(VALUE_BYTES + 1);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,  // waiting for a request beat
      ST_EXEC    = 4'b0010,  // parser updates with name store data
      ST_EMIT_RD = 4'b0100,  // value store read issued
      ST_EMIT_WR = 4'b1000   // read data into output register
   } state_type;

   state_type            state_ff, state_in;
   qsvl_pkg::req_type    item_ff;
   logic [VLW-1:0]       emit_idx_ff, emit_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   qsvl_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic                  exec, clear, accept, out_free, run_done;
   qsvl_pkg::summary_type summary;
   logic [VLW-1:0]        value_len, run_len, emit_idx_plus;
   logic                  val_we;
   logic [VAW-1:0]        val_waddr;
   logic [7:0]            val_wdata, val_rdata;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign exec     = (state_ff == ST_EXEC);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // number of value bytes in this run; zero means one empty beat
   assign run_len       = summary.found ? value_len : '0;
   assign emit_idx_plus = emit_idx_ff + 1'b1;
   assign run_done      = (run_len == '0) || (emit_idx_plus == run_len);
   assign clear         = (state_ff == ST_EMIT_WR) && out_free && run_done;

   qsvl_parser #(
      .MAX_PAIRS          (MAX_PAIRS),
      .QUERY_BUFFER_BYTES (QUERY_BUFFER_BYTES),
      .NAME_BYTES         (NAME_BYTES),
      .VALUE_BYTES        (VALUE_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .exec      (exec),
      .clear     (clear),
      .item      (item_ff),
      .summary   (summary),
      .value_len (value_len),
      .val_we    (val_we),
      .val_waddr (val_waddr),
      .val_wdata (val_wdata)
   );

   qsvl_value_buf #(
      .VALUE_BYTES (VALUE_BYTES)
   ) u_value_buf (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (val_wdata),
      .rd_addr (emit_idx_ff[VAW-1:0]),
      .rd_data (val_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      emit_idx_in  = emit_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (item_ff.mode == qsvl_pkg::MODE_QUERY && item_ff.last) begin
               emit_idx_in = '0;
               state_in    = ST_EMIT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            // read address is held here, so the read data stays valid
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.byte_valid = (run_len != '0);
               rsp_data_in.value_byte = (run_len != '0) ? val_rdata : 8'h00;
               rsp_data_in.run_last   = run_done;
               rsp_data_in.found      = summary.found;
               rsp_data_in.truncated  = summary.truncated;
               rsp_data_in.status     = summary.status;
               rsp_data_in.pair_total = summary.pair_total;
               if (run_done) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_plus;
                  state_in    = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         emit_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         emit_idx_ff  <= emit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== src/qsvl_checker.sv =====
`default_nettype none

module qsvl_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire qsvl_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire qsvl_pkg::rsp_type rsp_data
);

   // no output beat directly out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // an accepted name request beat is followed by req_stall high
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.mode == qsvl_pkg::MODE_NAME) |=> req_stall)
      else $error("request accepted on back-to-back cycles");

   // a stalled output beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("output beat changed while stalled");

   // empty beat carries a zero byte and is the only beat of its run
   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.byte_valid) |-> (rsp_data.value_byte == 8'h00 &&
                                              rsp_data.run_last))
      else $error("empty output beat malformed");

   // truncation only reported with a match
   a_trunc_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.truncated) |-> rsp_data.found)
      else $error("truncated without found");

endmodule

bind query_string_value_lookup_core qsvl_checker u_qsvl_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Sizing follows the core's default parameters.
   localparam int PAIR_LIMIT   = qsvl_pkg::MAX_PAIRS_DEF;
   localparam int QUERY_LIMIT  = qsvl_pkg::QUERY_BUFFER_BYTES_DEF;
   localparam int NAME_LIMIT   = qsvl_pkg::NAME_BYTES_DEF;
   localparam int VALUE_LIMIT  = qsvl_pkg::VALUE_BYTES_DEF;
   localparam int LONG_HOLDOFF = 400;  // receiver hold-off, in cycles
   localparam int DRAIN_CYCLES = 16;   // drain wait after the last predicted beat has arrived
   localparam logic [7:0] LETTER_A = 8'h61;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   qsvl_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   qsvl_pkg::rsp_type rsp_data;

   query_string_value_lookup_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // Run control shared by the stimulus, the receiver and the checker.
   int      error_count      = 0;
   int      items_sent       = 0;
   int      send_idle_pct    = 0;
   int      recv_idle_pct    = 0;
   int      holdoff_requests = 0;
   int      holdoff_served   = 0;
   int      holdoff_left     = 0;

   qsvl_pkg::rsp_type expected_value_beats[$];  // value beats predicted, oldest first
   logic [7:0]        outgoing[$];              // characters staged for the next send
   logic [7:0]        wanted_name[$];           // last name sent, used to build matching keys

   // ------------------------------------------------------------------
   // Lookup predictor: own copy of the name, parse and value state.
   // ------------------------------------------------------------------
   logic [7:0] name_chars [NAME_LIMIT];
   logic [7:0] value_chars [VALUE_LIMIT];
   int         name_len;
   bit         name_overlong;
   bit         name_sealed;
   bit         in_query;
   bit         in_value;
   bit         parse_done;
   bit         key_alive;
   bit         matched;
   bit         value_cut;
   int         query_count;
   int         key_pos;
   int         value_len;
   logic [3:0] pair_count;
   logic [1:0] end_code;

   function void restart_parse();
      in_value    = 1'b0;
      parse_done  = 1'b0;
      query_count = 0;
      pair_count  = '0;
      key_pos     = 0;
      key_alive   = 1'b1;
      value_len   = 0;
      matched     = 1'b0;
      value_cut   = 1'b0;
      end_code    = qsvl_pkg::STATUS_CLEAN;
   endfunction

   function void reset_lookup_state();
      name_len      = 0;
      name_overlong = 1'b0;
      name_sealed   = 1'b0;
      in_query      = 1'b0;
      restart_parse();
   endfunction

   // First completed pair whose key still matches wins.
   function void close_pair();
      pair_count++;
      if (key_alive && !matched) matched = 1'b1;
      in_value  = 1'b0;
      key_pos   = 0;
      key_alive = 1'b1;
   endfunction

   // A pending value counts as a pair on a clean or length end.
   function void stop_parse(logic [1:0] code);
      if (in_value) close_pair();
      parse_done = 1'b1;
      end_code   = code;
   endfunction

   function void parse_char(logic [7:0] b);
      if (b == qsvl_pkg::CHAR_NUL) begin
         stop_parse(qsvl_pkg::STATUS_CLEAN);
         return;
      end
      if (query_count >= QUERY_LIMIT - 1) begin
         stop_parse(qsvl_pkg::STATUS_LENGTH);
         return;
      end
      query_count++;
      if (b == qsvl_pkg::CHAR_EQUALS) begin
         if (in_value) begin
            // unfinished pair is dropped
            parse_done = 1'b1;
            end_code   = qsvl_pkg::STATUS_SYNTAX;
            return;
         end
         key_alive = key_alive && !name_overlong && key_pos == name_len && !matched;
         if (key_alive) begin
            value_len = 0;
            value_cut = 1'b0;
         end
         in_value = 1'b1;
      end else if (b == qsvl_pkg::CHAR_AMP) begin
         if (!in_value) begin
            parse_done = 1'b1;
            end_code   = qsvl_pkg::STATUS_SYNTAX;
            return;
         end
         close_pair();
         if (pair_count >= PAIR_LIMIT) begin
            parse_done = 1'b1;
            end_code   = qsvl_pkg::STATUS_PAIRS;
         end
      end else if (in_value) begin
         if (key_alive) begin
            if (value_len < VALUE_LIMIT) begin
               value_chars[value_len] = b;
               value_len++;
            end else begin
               value_cut = 1'b1;
            end
         end
      end else if (key_alive) begin
         if (key_pos < name_len && name_chars[key_pos] == b) key_pos++;
         else key_alive = 1'b0;
      end
   endfunction

   // Applies one accepted req beat; a query's last beat queues its value run.
   function void predict_lookup(qsvl_pkg::req_type item);
      qsvl_pkg::rsp_type beat;
      int                run_len;
      if (item.mode == qsvl_pkg::MODE_NAME) begin
         if (in_query) begin
            // new name abandons whatever the query left
            in_query      = 1'b0;
            name_len      = 0;
            name_overlong = 1'b0;
            name_sealed   = 1'b0;
            restart_parse();
         end
         if (!name_sealed) begin
            if (item.data_byte == qsvl_pkg::CHAR_NUL) begin
               name_sealed = 1'b1;
            end else if (name_len < NAME_LIMIT) begin
               name_chars[name_len] = item.data_byte;
               name_len++;
            end else begin
               name_overlong = 1'b1;
            end
            if (item.last) name_sealed = 1'b1;
         end
         return;
      end
      in_query    = 1'b1;
      name_sealed = 1'b1;
      if (!parse_done) begin
         parse_char(item.data_byte);
         if (item.last && !parse_done) stop_parse(qsvl_pkg::STATUS_CLEAN);
      end
      if (!item.last) return;
      run_len         = matched ? value_len : 0;
      beat            = '0;
      beat.found      = matched;
      beat.truncated  = matched && value_cut;
      beat.status     = end_code;
      beat.pair_total = pair_count;
      if (run_len == 0) begin
         beat.run_last = 1'b1;
         expected_value_beats.push_back(beat);
      end else begin
         for (int k = 0; k < run_len; k++) begin
            beat.value_byte = value_chars[k];
            beat.byte_valid = 1'b1;
            beat.run_last   = (k == run_len - 1);
            expected_value_beats.push_back(beat);
         end
      end
      restart_parse();
   endfunction

   // ------------------------------------------------------------------
   // Receiver: random stall, or a long hold-off when one is requested.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (holdoff_served != holdoff_requests) begin
         holdoff_served <= holdoff_requests;
         holdoff_left   <= LONG_HOLDOFF;
         rsp_stall      <= 1'b1;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Checker: every accepted rsp beat against the oldest prediction.
   // ------------------------------------------------------------------
   function void compare_field(string label, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want_v, got_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      qsvl_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_value_beats.size() == 0) begin
            $display("%0t: unexpected rsp beat, expected none, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_value_beats.pop_front();
            compare_field("value_byte", want.value_byte, rsp_data.value_byte);
            compare_field("byte_valid", 8'(want.byte_valid), 8'(rsp_data.byte_valid));
            compare_field("run_last",   8'(want.run_last),   8'(rsp_data.run_last));
            compare_field("found",      8'(want.found),      8'(rsp_data.found));
            compare_field("truncated",  8'(want.truncated),  8'(rsp_data.truncated));
            compare_field("status",     8'(want.status),     8'(rsp_data.status));
            compare_field("pair_total", 8'(want.pair_total), 8'(rsp_data.pair_total));
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender helpers.
   // ------------------------------------------------------------------
   // Mostly a..c so keys collide with the name; otherwise any nonzero byte but '=' and '&'.
   function automatic logic [7:0] content_char();
      logic [7:0] c;
      if ($urandom_range(9) < 8) return LETTER_A + 8'($urandom_range(2));
      do c = 8'($urandom_range(1, 255));
      while (c == qsvl_pkg::CHAR_EQUALS || c == qsvl_pkg::CHAR_AMP);
      return c;
   endfunction

   function automatic logic [7:0] noise_char();
      case ($urandom_range(3))
         0: return qsvl_pkg::CHAR_NUL;
         1: return qsvl_pkg::CHAR_EQUALS;
         2: return qsvl_pkg::CHAR_AMP;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function void push_text(string s);
      for (int i = 0; i < s.len(); i++) outgoing.push_back(s[i]);
   endfunction

   // One req beat; valid stays high into the next call unless an idle cycle comes.
   task automatic send_char(logic mode, logic [7:0] char_byte, logic last);
      qsvl_pkg::req_type item;
      item.mode      = mode;
      item.data_byte = char_byte;
      item.last      = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_lookup(item);
      items_sent++;
   endtask

   task automatic send_outgoing(logic mode, bit last_at_end);
      for (int i = 0; i < outgoing.size(); i++)
         send_char(mode, outgoing[i], last_at_end && i == outgoing.size() - 1);
      outgoing.delete();
   endtask

   // Sender pause: nothing offered until every predicted beat has arrived.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_value_beats.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------
   // Simple hit; the value byte is all ones.
   task automatic test_basic_lookup();
      push_text("a");
      send_outgoing(qsvl_pkg::MODE_NAME, 1'b1);
      push_text("a=");
      send_outgoing(qsvl_pkg::MODE_QUERY, 1'b0);
      send_char(qsvl_pkg::MODE_QUERY, 8'hFF, 1'b1);
   endtask

   // Query ended by a zero byte with an empty value, then an empty name
   // that matches an empty key.
   task automatic test_empty_value_and_name();
      push_text("a=");
      outgoing.push_back(qsvl_pkg::CHAR_NUL);
      send_outgoing(qsvl_pkg::MODE_QUERY, 1'b1);
      send_char(qsvl_pkg::MODE_NAME, qsvl_pkg::CHAR_NUL, 1'b1);
      push_text("=v");
      send_outgoing(qsvl_pkg::MODE_QUERY, 1'b1);
   endtask

   // '&' inside a key, and '=' inside a value after a matching key:
   // the broken pair must not count as found.
   task automatic test_syntax_errors();
      send_char(qsvl_pkg::MODE_QUERY, qsvl_pkg::CHAR_AMP, 1'b1);
      push_text("=b=c");
      send_outgoing(qsvl_pkg::MODE_QUERY, 1'b1);
   endtask

   // Unfinished name closed by a query, an abandoned query, ignored name
   // bytes after the terminator, and a query ending inside a key.
   task automatic test_name_boundaries();
      push_text("q");
      send_outgoing(qsvl_pkg::MODE_NAME, 1'b0);
      push_text("q=1");
      send_outgoing(qsvl_pkg::MODE_QUERY, 1'b0);
      push_text("ab");
      outgoing.push_back(qsvl_pkg::CHAR_NUL);
      push_text("z");
      send_outgoing(qsvl_pkg::MODE_NAME, 1'b1);
      push_text("ab");
      send_outgoing(qsvl_pkg::MODE_QUERY, 1'b1);
   endtask

   // Sixteen pairs: the '&' after the fifteenth ends the parse. Then
   // exactly fifteen, the last completed by the end of the query.
   task automatic test_pair_limit();
      push_text("p");
      send_outgoing(qsvl_pkg::MODE_NAME, 1'b1);
      for (int v = 0; v < 2; v++) begin
         for (int k = 0; k < PAIR_LIMIT + 1 - v; k++) begin
            if (k != 0) outgoing.push_back(qsvl_pkg::CHAR_AMP);
            push_text(k >= PAIR_LIMIT - 1 ? "p=" : "x=");
            outgoing.push_back(content_char());
         end
         send_outgoing(qsvl_pkg::MODE_QUERY, 1'b1);
      end
   endtask

   // Query filling the buffer: one more content byte ends with the length
   // status (matched value truncated); a zero byte there ends cleanly.
   task automatic test_length_limit();
      push_text("k");
      send_outgoing(qsvl_pkg::MODE_NAME, 1'b1);
      for (int v = 0; v < 2; v++) begin
         push_text(v == 0 ? "k=" : "x=");
         repeat (QUERY_LIMIT - 3) outgoing.push_back(content_char());
         if (v == 0) begin
            outgoing.push_back(content_char());
            outgoing.push_back(noise_char());
         end else begin
            outgoing.push_back(qsvl_pkg::CHAR_NUL);
         end
         send_outgoing(qsvl_pkg::MODE_QUERY, 1'b1);
      end
   endtask

   // Receiver holds off for a long stretch while several hits queue up
   // behind it, so the core stalls its req side.
   task automatic test_backpressure();
      holdoff_requests <= holdoff_requests + 1;
      push_text("v");
      send_outgoing(qsvl_pkg::MODE_NAME, 1'b1);
      repeat (4) begin
         push_text("v=");
         repeat ($urandom_range(12, 20)) outgoing.push_back(content_char());
         send_outgoing(qsvl_pkg::MODE_QUERY, 1'b1);
      end
      wait_for_results();
   endtask

   // Mostly well-formed name + query lookups with random content; some
   // noise bytes, odd terminations and abandoned queries mixed in.
   task automatic test_random_lookups(int sender_pct, int receiver_pct, int item_goal);
      int stop_at;
      int pick;
      int pairs;
      int vlen;
      bit name_due;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      stop_at       = items_sent + item_goal;
      name_due      = 1'b1;
      while (items_sent < stop_at) begin
         // name: usually a new one, sometimes the stored one is reused
         if (name_due || $urandom_range(99) < 80) begin
            name_due = 1'b0;
            pick     = $urandom_range(99);
            wanted_name.delete();
            if (pick >= 90) begin
               repeat ($urandom_range(30, 34)) wanted_name.push_back(content_char());
            end else if (pick >= 6) begin
               repeat ($urandom_range(1, 3)) wanted_name.push_back(content_char());
            end
            outgoing = wanted_name;
            case ($urandom_range(3))
               0: begin
                  if (outgoing.size() == 0) outgoing.push_back(qsvl_pkg::CHAR_NUL);
                  send_outgoing(qsvl_pkg::MODE_NAME, 1'b1);
               end
               1: begin
                  outgoing.push_back(qsvl_pkg::CHAR_NUL);
                  send_outgoing(qsvl_pkg::MODE_NAME, 1'b1);
               end
               2: begin
                  // bytes after the terminator are ignored
                  outgoing.push_back(qsvl_pkg::CHAR_NUL);
                  repeat ($urandom_range(1, 2)) outgoing.push_back(content_char());
                  send_outgoing(qsvl_pkg::MODE_NAME, 1'($urandom_range(1)));
               end
               default: send_outgoing(qsvl_pkg::MODE_NAME, 1'b0);  // query closes it
            endcase
         end

         // query: key=value pairs, keys often equal or close to the name
         pairs = ($urandom_range(99) < 75) ? $urandom_range(0, 4) : $urandom_range(5, 9);
         for (int p = 0; p < pairs; p++) begin
            if (p != 0) outgoing.push_back(qsvl_pkg::CHAR_AMP);
            pick = $urandom_range(99);
            if (pick < 60) begin
               foreach (wanted_name[i]) outgoing.push_back(wanted_name[i]);
               if (pick >= 45) outgoing.push_back(content_char());
            end else if (pick < 72 && wanted_name.size() > 1) begin
               for (int i = 0; i < wanted_name.size() - 1; i++)
                  outgoing.push_back(wanted_name[i]);
            end else begin
               repeat ($urandom_range(3)) outgoing.push_back(content_char());
            end
            outgoing.push_back(qsvl_pkg::CHAR_EQUALS);
            vlen = ($urandom_range(99) < 85) ? $urandom_range(0, 5) : $urandom_range(28, 40);
            repeat (vlen) outgoing.push_back(content_char());
         end
         if ($urandom_range(99) < 15) begin
            if (outgoing.size() == 0) outgoing.push_back(noise_char());
            else outgoing.insert($urandom_range(outgoing.size() - 1), noise_char());
         end

         if ($urandom_range(99) < 6) begin
            // abandoned: the next lookup starts a new name without a last beat
            if (outgoing.size() == 0) outgoing.push_back(content_char());
            send_outgoing(qsvl_pkg::MODE_QUERY, 1'b0);
            name_due = 1'b1;
         end else begin
            case ($urandom_range(3))
               0, 1: begin
                  if (outgoing.size() == 0) outgoing.push_back(qsvl_pkg::CHAR_NUL);
                  send_outgoing(qsvl_pkg::MODE_QUERY, 1'b1);
               end
               2: begin
                  outgoing.push_back(qsvl_pkg::CHAR_NUL);
                  send_outgoing(qsvl_pkg::MODE_QUERY, 1'b1);
               end
               default: begin
                  // zero byte ends the parse; trailing bytes up to last are ignored
                  outgoing.push_back(qsvl_pkg::CHAR_NUL);
                  repeat ($urandom_range(1, 3)) outgoing.push_back(noise_char());
                  send_outgoing(qsvl_pkg::MODE_QUERY, 1'b1);
               end
            endcase
         end
      end
      wait_for_results();
   endtask

   // ------------------------------------------------------------------
   // Sequence.
   // ------------------------------------------------------------------
   initial begin
      reset_lookup_state();
      send_idle_pct = 8;
      recv_idle_pct = 55;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_basic_lookup();
      test_empty_value_and_name();
      test_syntax_errors();
      test_name_boundaries();
      test_pair_limit();
      test_length_limit();
      test_backpressure();
      test_random_lookups(8, 55, 170);
      test_random_lookups(55, 8, 170);
      test_random_lookups(0, 0, 170);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
src/qsvl_pkg.sv
src/qsvl_value_buf.sv
src/qsvl_parser.sv
src/query_string_value_lookup_core.sv
src/qsvl_checker.sv
verif/tb.sv
